// ===== design/market_vwap_and_weighted_mid_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// market vwap tracker assertion macros
// shared property forms for the tracker's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MARKET_VWAP_AND_WEIGHTED_MID_TRACKER_ASSERT_SVH
`define MARKET_VWAP_AND_WEIGHTED_MID_TRACKER_ASSERT_SVH

// same-cycle implication
`define MVWAP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mvwap check failed");

// next-cycle implication
`define MVWAP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mvwap check failed");

`endif

// ===== design/mvwap_pkg.sv =====
// ----------------------------------------------------------------------------
// mvwap_pkg
// types and constants shared by the vwap and weighted mid tracker
// ----------------------------------------------------------------------------
package mvwap_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = 3;
   localparam int PX_W       = 48;
   localparam int QTY_W      = 32;
   localparam int SQ_W       = 35;
   localparam int VOL_W      = 48;
   localparam int NOT_W      = 128;
   localparam int CHUNK_W    = 24;
   localparam int MQ_W       = 35;
   localparam int PROD_W     = 83;
   localparam int DIV_CNT_W  = 7;
   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 488;

   localparam logic [PX_W-1:0] PX_UNDEF = 48'h7FFF_FFFF_FFFF;
   localparam logic [PX_W-1:0] PX_MIN   = 48'h8000_0000_0000;

   localparam logic       OP_TRADE  = 1'b0;
   localparam logic       OP_TOP    = 1'b1;
   localparam logic [1:0] SIDE_BID  = 2'd0;
   localparam logic [1:0] SIDE_ASK  = 2'd1;
   localparam logic [1:0] SIDE_NONE = 2'd2;

   typedef enum logic [1:0] {
      JOB_TRADE = 2'd0,
      JOB_MID_A = 2'd1,
      JOB_MID_B = 2'd2
   } job_type;

   typedef enum logic [11:0] {
      S_IDLE       = 12'b0000_0000_0001,
      S_LOAD       = 12'b0000_0000_0010,
      S_MERGE_INIT = 12'b0000_0000_0100,
      S_MERGE      = 12'b0000_0000_1000,
      S_CHECK      = 12'b0000_0001_0000,
      S_MUL_LO     = 12'b0000_0010_0000,
      S_MUL_HI     = 12'b0000_0100_0000,
      S_ACC        = 12'b0000_1000_0000,
      S_DIV_INIT   = 12'b0001_0000_0000,
      S_DIV        = 12'b0010_0000_0000,
      S_DIV_END    = 12'b0100_0000_0000,
      S_DONE       = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic    take;
      logic    apply;
      logic    merge_init;
      logic    merge_step;
      logic    mul_load;
      logic    mul_step;
      logic    mul_acc;
      logic    div_load;
      logic    div_step;
      logic    div_store;
      logic    out_load;
      job_type job;
   } cmd_type;

   typedef struct packed {
      logic is_trade;
      logic do_merge;
      logic vol_zero;
      logic mid_ok;
      logic merge_last;
      logic div_last;
      logic rsp_free;
   } status_type;

endpackage

// ===== design/market_vwap_and_weighted_mid_tracker.sv =====
// ----------------------------------------------------------------------------
// market_vwap_and_weighted_mid_tracker
// vwap, trade range, last trade, merged book tops and weighted mid
//
// channel  dir  beat contents
// req      in   tdata: slot, side, price, quantity; tuser: op, is_fill, price_absent;
//                tlast: end_of_event
// rsp      out  tdata: vwap .. last_side, one beat per req beat
//
// an item without arithmetic goes from load straight to a waiting result
// a priced trade runs 2 multiply steps and, unless the volume is zero, 128 divide steps
// a merging top update runs 8 slot walk steps and, when both merged tops are valid,
// 4 multiply steps and 128 divide steps; the serial divider dominates
// reset is synchronous; it clears slot tops, statistics and control, not the latched item or result data
// a stalled result beat holds; the next req beat is taken while it waits
// ----------------------------------------------------------------------------
module market_vwap_and_weighted_mid_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // slot, side, price, quantity
   input  logic [mvwap_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op, is_fill, price_absent
   input  logic [mvwap_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // vwap, weighted_mid, trade high, trade low, best_bid_price, best_bid_qty,
   // best_ask_price, best_ask_qty, total_volume, last_price, last_qty, last_side
   output logic [mvwap_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   mvwap_pkg::cmd_type    cmd;
   mvwap_pkg::status_type sts;

   mvwap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mvwap_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ===== design/mvwap_ctrl.sv =====
// ----------------------------------------------------------------------------
// mvwap_ctrl
// sequencer for decode, slot merge, multiply and divide of one item
// ----------------------------------------------------------------------------
`include "market_vwap_and_weighted_mid_tracker_assert.svh"

module mvwap_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  mvwap_pkg::status_type  sts,
   output mvwap_pkg::cmd_type     cmd
);

   mvwap_pkg::state_type state_ff, state_in;
   mvwap_pkg::job_type   job_ff, job_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mvwap_pkg::S_IDLE;
         job_ff   <= mvwap_pkg::JOB_TRADE;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   assign req_tready = (state_ff == mvwap_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      cmd      = '0;
      cmd.job  = job_ff;
      case (state_ff)
         mvwap_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = mvwap_pkg::S_LOAD;
            end
         end
         mvwap_pkg::S_LOAD: begin
            cmd.apply = 1'b1;
            if (sts.is_trade) begin
               cmd.mul_load = 1'b1;
               cmd.job      = mvwap_pkg::JOB_TRADE;
               job_in       = mvwap_pkg::JOB_TRADE;
               state_in     = mvwap_pkg::S_MUL_LO;
            end else if (sts.do_merge) begin
               state_in = mvwap_pkg::S_MERGE_INIT;
            end else begin
               state_in = mvwap_pkg::S_DONE;
            end
         end
         mvwap_pkg::S_MERGE_INIT: begin
            cmd.merge_init = 1'b1;
            state_in       = mvwap_pkg::S_MERGE;
         end
         mvwap_pkg::S_MERGE: begin
            cmd.merge_step = 1'b1;
            if (sts.merge_last) begin
               state_in = mvwap_pkg::S_CHECK;
            end
         end
         mvwap_pkg::S_CHECK: begin
            if (sts.mid_ok) begin
               cmd.mul_load = 1'b1;
               cmd.job      = mvwap_pkg::JOB_MID_A;
               job_in       = mvwap_pkg::JOB_MID_A;
               state_in     = mvwap_pkg::S_MUL_LO;
            end else begin
               state_in = mvwap_pkg::S_DONE;
            end
         end
         mvwap_pkg::S_MUL_LO: begin
            cmd.mul_step = 1'b1;
            state_in     = mvwap_pkg::S_MUL_HI;
         end
         mvwap_pkg::S_MUL_HI: begin
            cmd.mul_step = 1'b1;
            state_in     = mvwap_pkg::S_ACC;
         end
         mvwap_pkg::S_ACC: begin
            cmd.mul_acc = 1'b1;
            case (job_ff)
               mvwap_pkg::JOB_TRADE: begin
                  state_in = sts.vol_zero ? mvwap_pkg::S_DONE : mvwap_pkg::S_DIV_INIT;
               end
               mvwap_pkg::JOB_MID_A: begin
                  // first product stored while the second operand pair loads
                  cmd.mul_load = 1'b1;
                  cmd.job      = mvwap_pkg::JOB_MID_B;
                  job_in       = mvwap_pkg::JOB_MID_B;
                  state_in     = mvwap_pkg::S_MUL_LO;
               end
               default: begin
                  state_in = mvwap_pkg::S_DIV_INIT;
               end
            endcase
         end
         mvwap_pkg::S_DIV_INIT: begin
            cmd.div_load = 1'b1;
            state_in     = mvwap_pkg::S_DIV;
         end
         mvwap_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = mvwap_pkg::S_DIV_END;
            end
         end
         mvwap_pkg::S_DIV_END: begin
            cmd.div_store = 1'b1;
            state_in      = mvwap_pkg::S_DONE;
         end
         mvwap_pkg::S_DONE: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = mvwap_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mvwap_pkg::S_IDLE;
         end
      endcase
   end

   `MVWAP_ASSERT_NEXT(a_take_loads, clock, reset, cmd.take, state_ff == mvwap_pkg::S_LOAD)
   `MVWAP_ASSERT_NOW(a_out_free, clock, reset, cmd.out_load, sts.rsp_free)
   `MVWAP_ASSERT_NOW(a_store_after_last, clock, reset, cmd.div_store, $past(sts.div_last))
   `MVWAP_ASSERT_NEXT(a_merge_runs, clock, reset, cmd.merge_init, state_ff == mvwap_pkg::S_MERGE)

endmodule

// ===== design/mvwap_dp.sv =====
// ----------------------------------------------------------------------------
// mvwap_dp
// tracker state, slot tops, merge walk, split multiplier and serial divider
// ----------------------------------------------------------------------------
module mvwap_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mvwap_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [mvwap_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mvwap_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  mvwap_pkg::cmd_type                  cmd,
   output mvwap_pkg::status_type               sts
);

   localparam int PW = mvwap_pkg::PX_W;
   localparam int NB = mvwap_pkg::SLOT_COUNT;
   localparam int VOL_W_SUM = mvwap_pkg::VOL_W;

   // latched item
   logic                         op_ff, fill_ff, last_ff, absent_ff;
   logic [mvwap_pkg::SLOT_W-1:0] slot_ff;
   logic [1:0]                   side_ff;
   logic signed [PW-1:0]         price_ff;
   logic [mvwap_pkg::QTY_W-1:0]  qty_ff;

   // slot tops
   logic signed [PW-1:0]         sbid_px_ff [NB];
   logic [mvwap_pkg::QTY_W-1:0]  sbid_q_ff  [NB];
   logic signed [PW-1:0]         sask_px_ff [NB];
   logic [mvwap_pkg::QTY_W-1:0]  sask_q_ff  [NB];

   // statistics
   logic [mvwap_pkg::VOL_W-1:0]  vol_ff;
   logic [mvwap_pkg::NOT_W-1:0]  notional_ff;
   logic signed [PW-1:0]         vwap_ff, mid_ff, high_ff, low_ff, tpx_ff;
   logic [mvwap_pkg::QTY_W-1:0]  tq_ff;
   logic [1:0]                   tside_ff;
   logic signed [PW-1:0]         mbpx_ff, mapx_ff;
   logic [mvwap_pkg::SQ_W-1:0]   mbq_ff, maq_ff;
   logic [mvwap_pkg::SLOT_W-1:0] idx_ff;

   // multiplier and divider
   logic [PW-1:0]                  mag_ff;
   logic [mvwap_pkg::MQ_W-1:0]     mq_ff;
   logic                           mneg_ff, mstep_ff;
   logic [mvwap_pkg::PROD_W-1:0]   acc_ff;
   logic [mvwap_pkg::NOT_W-1:0]    mnum_ff, dn_ff;
   logic [PW-1:0]                  rem_ff, dd_ff;
   logic                           dneg_ff;
   logic [mvwap_pkg::DIV_CNT_W-1:0] dcnt_ff;

   logic                         rvalid_ff;
   logic [mvwap_pkg::RSP_DATA_W-1:0] rdata_ff;

   logic [mvwap_pkg::SQ_W:0]     total;
   logic [VOL_W_SUM:0]           vsum;
   logic signed [PW-1:0]         bp, ap, mp;
   logic [mvwap_pkg::SQ_W:0]     bsum, asum;
   logic [mvwap_pkg::MQ_W-1:0]   mqsel;
   logic [mvwap_pkg::CHUNK_W-1:0] chunk;
   logic [mvwap_pkg::CHUNK_W+mvwap_pkg::MQ_W-1:0] pp;
   logic [mvwap_pkg::NOT_W-1:0]  pext, sprod, nsel, nmag;
   logic [PW:0]                  rs;
   logic                         ge;
   logic signed [PW-1:0]         qsat;

   assign total = {1'b0, mbq_ff} + {1'b0, maq_ff};
   assign vsum  = {1'b0, vol_ff} + {17'b0, qty_ff};
   assign bp    = sbid_px_ff[idx_ff];
   assign ap    = sask_px_ff[idx_ff];
   assign bsum  = {1'b0, mbq_ff} + {4'b0, sbid_q_ff[idx_ff]};
   assign asum  = {1'b0, maq_ff} + {4'b0, sask_q_ff[idx_ff]};

   always_comb begin
      case (cmd.job)
         mvwap_pkg::JOB_TRADE: begin
            mp    = price_ff;
            mqsel = {3'b0, qty_ff};
         end
         mvwap_pkg::JOB_MID_A: begin
            mp    = mbpx_ff;
            mqsel = maq_ff;
         end
         default: begin
            mp    = mapx_ff;
            mqsel = mbq_ff;
         end
      endcase
   end

   assign chunk = mstep_ff ? mag_ff[PW-1:mvwap_pkg::CHUNK_W] : mag_ff[mvwap_pkg::CHUNK_W-1:0];
   assign pp    = chunk * mq_ff;
   assign pext  = {45'b0, acc_ff};
   assign sprod = mneg_ff ? (~pext + 128'd1) : pext;
   assign nsel  = (cmd.job == mvwap_pkg::JOB_TRADE) ? notional_ff : mnum_ff;
   assign nmag  = nsel[mvwap_pkg::NOT_W-1] ? (~nsel + 128'd1) : nsel;
   assign rs    = {rem_ff, dn_ff[mvwap_pkg::NOT_W-1]};
   assign ge    = rs >= {1'b0, dd_ff};

   always_comb begin
      if (dneg_ff) begin
         if (dn_ff[mvwap_pkg::NOT_W-1:PW] != '0 || dn_ff[PW-1:0] > mvwap_pkg::PX_MIN) begin
            qsat = mvwap_pkg::PX_MIN;
         end else begin
            qsat = ~dn_ff[PW-1:0] + 48'd1;
         end
      end else begin
         if (dn_ff[mvwap_pkg::NOT_W-1:PW-1] != '0) begin
            qsat = mvwap_pkg::PX_UNDEF;
         end else begin
            qsat = dn_ff[PW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         slot_ff   <= req_tdata[2:0];
         side_ff   <= req_tdata[4:3];
         price_ff  <= req_tdata[52:5];
         qty_ff    <= req_tdata[84:53];
         op_ff     <= req_tuser[0];
         fill_ff   <= req_tuser[1];
         absent_ff <= req_tuser[2];
         last_ff   <= req_tlast;
      end
      if (cmd.mul_load) begin
         mag_ff   <= mp[PW-1] ? (~mp + 48'd1) : mp;
         mneg_ff  <= mp[PW-1];
         mq_ff    <= mqsel;
         acc_ff   <= '0;
         mstep_ff <= 1'b0;
      end else if (cmd.mul_step) begin
         acc_ff   <= mstep_ff ? acc_ff + {pp, 24'b0} : acc_ff + {24'b0, pp};
         mstep_ff <= ~mstep_ff;
      end
      if (cmd.mul_acc && cmd.job != mvwap_pkg::JOB_TRADE) begin
         mnum_ff <= cmd.mul_load ? sprod : mnum_ff + sprod;
      end
      if (cmd.div_load) begin
         dn_ff   <= nmag;
         dneg_ff <= nsel[mvwap_pkg::NOT_W-1];
         dd_ff   <= (cmd.job == mvwap_pkg::JOB_TRADE) ? vol_ff : {12'b0, total};
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? PW'(rs - {1'b0, dd_ff}) : rs[PW-1:0];
         dn_ff  <= {dn_ff[mvwap_pkg::NOT_W-2:0], ge};
      end
      if (cmd.out_load) begin
         rdata_ff <= {tside_ff, tq_ff, tpx_ff, vol_ff, maq_ff, mapx_ff, mbq_ff, mbpx_ff,
                      low_ff, high_ff, mid_ff, vwap_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NB; i++) begin
            sbid_px_ff[i] <= mvwap_pkg::PX_UNDEF;
            sbid_q_ff[i]  <= '0;
            sask_px_ff[i] <= mvwap_pkg::PX_UNDEF;
            sask_q_ff[i]  <= '0;
         end
         vol_ff      <= '0;
         notional_ff <= '0;
         vwap_ff     <= mvwap_pkg::PX_UNDEF;
         mid_ff      <= mvwap_pkg::PX_UNDEF;
         high_ff     <= mvwap_pkg::PX_MIN;
         low_ff      <= mvwap_pkg::PX_UNDEF;
         mbpx_ff     <= mvwap_pkg::PX_UNDEF;
         mapx_ff     <= mvwap_pkg::PX_UNDEF;
         mbq_ff      <= '0;
         maq_ff      <= '0;
         tpx_ff      <= '0;
         tq_ff       <= '0;
         tside_ff    <= mvwap_pkg::SIDE_NONE;
         idx_ff      <= '0;
         dcnt_ff     <= '0;
         rvalid_ff   <= 1'b0;
      end else begin
         if (cmd.apply) begin
            if (op_ff == mvwap_pkg::OP_TRADE && !absent_ff) begin
               vol_ff   <= vsum[mvwap_pkg::VOL_W] ? '1 : vsum[mvwap_pkg::VOL_W-1:0];
               tpx_ff   <= price_ff;
               tq_ff    <= qty_ff;
               tside_ff <= (side_ff > mvwap_pkg::SIDE_NONE) ? mvwap_pkg::SIDE_NONE : side_ff;
               if (price_ff > high_ff) high_ff <= price_ff;
               if (price_ff < low_ff) low_ff <= price_ff;
            end
            if (op_ff == mvwap_pkg::OP_TOP && int'(slot_ff) < NB) begin
               if (side_ff == mvwap_pkg::SIDE_BID) begin
                  sbid_px_ff[slot_ff] <= price_ff;
                  sbid_q_ff[slot_ff]  <= qty_ff;
               end else if (side_ff == mvwap_pkg::SIDE_ASK) begin
                  sask_px_ff[slot_ff] <= price_ff;
                  sask_q_ff[slot_ff]  <= qty_ff;
               end
            end
         end
         if (cmd.merge_init) begin
            mbpx_ff <= mvwap_pkg::PX_UNDEF;
            mapx_ff <= mvwap_pkg::PX_UNDEF;
            mbq_ff  <= '0;
            maq_ff  <= '0;
            idx_ff  <= '0;
         end else if (cmd.merge_step) begin
            if (bp != '0 && bp != mvwap_pkg::PX_UNDEF) begin
               if (mbpx_ff == mvwap_pkg::PX_UNDEF || bp > mbpx_ff) begin
                  mbpx_ff <= bp;
                  mbq_ff  <= {3'b0, sbid_q_ff[idx_ff]};
               end else if (bp == mbpx_ff) begin
                  mbq_ff <= bsum[mvwap_pkg::SQ_W] ? '1 : bsum[mvwap_pkg::SQ_W-1:0];
               end
            end
            if (ap != '0 && ap != mvwap_pkg::PX_UNDEF) begin
               if (ap < mapx_ff) begin
                  mapx_ff <= ap;
                  maq_ff  <= {3'b0, sask_q_ff[idx_ff]};
               end else if (ap == mapx_ff) begin
                  maq_ff <= asum[mvwap_pkg::SQ_W] ? '1 : asum[mvwap_pkg::SQ_W-1:0];
               end
            end
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.mul_acc && cmd.job == mvwap_pkg::JOB_TRADE) begin
            notional_ff <= notional_ff + sprod;
         end
         if (cmd.div_load) begin
            dcnt_ff <= '0;
         end else if (cmd.div_step) begin
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         if (cmd.div_store) begin
            if (cmd.job == mvwap_pkg::JOB_TRADE) vwap_ff <= qsat;
            else mid_ff <= qsat;
         end
         if (cmd.out_load) begin
            rvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end

   assign sts.is_trade   = (op_ff == mvwap_pkg::OP_TRADE) && !absent_ff;
   assign sts.do_merge   = (op_ff == mvwap_pkg::OP_TOP) && !absent_ff && !fill_ff && last_ff;
   assign sts.vol_zero   = (vol_ff == '0);
   assign sts.mid_ok     = (total != '0) && (mbpx_ff != mvwap_pkg::PX_UNDEF)
                           && (mapx_ff != mvwap_pkg::PX_UNDEF);
   assign sts.merge_last = (int'(idx_ff) == NB - 1);
   assign sts.div_last   = (dcnt_ff == '1);
   assign sts.rsp_free   = !rvalid_ff || rsp_tready;

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

endmodule
